// ===== sv/sx7_pkg.sv =====
// Package for the SysEx 7-bit packet decoder.
// Holds the protocol byte codes, the queue depth and the command type.
// Used by every module of the block; depends on nothing.
package sx7_pkg;

    localparam logic [7:0] StartByte  = 8'hF0;
    localparam logic [7:0] EndByte    = 8'hF7;
    localparam logic [7:0] IdReset    = 8'h12;
    localparam logic [2:0] LastIdx    = 3'd6;   // seven data bytes per group

    localparam int QDepth = 2;
    localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
    localparam int QCntW  = $clog2(QDepth + 1);

    // Result kinds.
    localparam logic KindData  = 1'b0;
    localparam logic KindError = 1'b1;

    typedef enum logic [1:0] {
        OP_HIGH = 2'd0,   // load the high-bit byte of a group
        OP_DATA = 2'd1,   // emit one decoded data byte
        OP_ERR  = 2'd2    // emit an identifier mismatch
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [2:0] idx;
        logic [7:0] data;
    } t_cmd;

endpackage

// ===== sv/sx7_in_if.sv =====
// Input channel of the SysEx decoder: one received MIDI byte per item.
// Depends on nothing.
interface sx7_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

// ===== sv/sx7_out_if.sv =====
// Output channel of the SysEx decoder: one decoded byte or error per item.
// Depends on nothing.
interface sx7_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] out_byte;

    modport source (output valid, output kind, output out_byte, input ready);
    modport sink   (input valid, input kind, input out_byte, output ready);
endinterface

// ===== sv/sx7_front.sv =====
// Front end of the SysEx decoder: packet framing, identifier check and
// group counting. Pushes commands into the queue. Depends on sx7_pkg, sx7_in_if.
module sx7_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    sx7_in_if.sink         i_in,
    input  logic           i_cfg_wr_en,
    input  logic [7:0]     i_cfg_wr_data,
    input  logic           i_q_full,
    output logic           o_push,
    output sx7_pkg::t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        PH_HUNT = 4'b0001,
        PH_ID   = 4'b0010,
        PH_HIGH = 4'b0100,
        PH_DATA = 4'b1000
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [2:0] r_idx, n_idx;
    logic [7:0] r_expected_id;
    logic       accept;
    logic [7:0] b;
    logic       is_end;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && i_in.ready;
    assign b          = i_in.in_byte;
    assign is_end     = (b == sx7_pkg::EndByte);

    always_comb begin
        n_phase    = r_phase;
        n_idx      = r_idx;
        o_push     = 1'b0;
        o_cmd.op   = sx7_pkg::OP_DATA;
        o_cmd.idx  = r_idx;
        o_cmd.data = b;
        if (accept) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (b == sx7_pkg::StartByte) begin
                        n_phase = PH_ID;
                    end
                end
                PH_ID: begin
                    if (is_end) begin
                        n_phase = PH_HUNT;
                        n_idx   = 3'd0;
                    end else begin
                        n_phase = PH_HIGH;
                        // A wrong identifier is reported, then decoding goes on.
                        if (b != r_expected_id) begin
                            o_push   = 1'b1;
                            o_cmd.op = sx7_pkg::OP_ERR;
                        end
                    end
                end
                PH_HIGH: begin
                    if (is_end) begin
                        n_phase = PH_HUNT;
                        n_idx   = 3'd0;
                    end else begin
                        o_push   = 1'b1;
                        o_cmd.op = sx7_pkg::OP_HIGH;
                        n_idx    = 3'd0;
                        n_phase  = PH_DATA;
                    end
                end
                PH_DATA: begin
                    if (is_end) begin
                        n_phase = PH_HUNT;
                        n_idx   = 3'd0;
                    end else begin
                        o_push   = 1'b1;
                        o_cmd.op = sx7_pkg::OP_DATA;
                        if (r_idx == sx7_pkg::LastIdx) begin
                            n_idx   = 3'd0;
                            n_phase = PH_HIGH;
                        end else begin
                            n_idx = r_idx + 3'd1;
                        end
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                    n_idx   = 3'd0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HUNT;
            r_idx         <= 3'd0;
            r_expected_id <= sx7_pkg::IdReset;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            if (i_cfg_wr_en) begin
                r_expected_id <= i_cfg_wr_data;
            end
        end
    end

`ifndef SYNTHESIS
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= sx7_pkg::LastIdx)
        else $error("group index past the last data byte");

    a_end_hunts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && is_end && r_phase != PH_HUNT) |=> (r_phase == PH_HUNT && r_idx == 3'd0))
        else $error("end byte did not return to hunting");
`endif

endmodule

// ===== sv/sx7_fifo.sv =====
// Short command queue between the front end and the back end of the decoder.
// Depends on sx7_pkg.
module sx7_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sx7_pkg::t_cmd  i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output sx7_pkg::t_cmd  o_cmd
);

    sx7_pkg::t_cmd                 r_mem [sx7_pkg::QDepth];
    logic [sx7_pkg::QPtrW-1:0]     r_wr_ptr, r_rd_ptr;
    logic [sx7_pkg::QCntW-1:0]     r_count;
    logic                          do_push, do_pop;

    assign o_full  = (r_count == sx7_pkg::QCntW'(sx7_pkg::QDepth));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    function automatic logic [sx7_pkg::QPtrW-1:0] bump(input logic [sx7_pkg::QPtrW-1:0] p);
        if (p == sx7_pkg::QPtrW'(sx7_pkg::QDepth - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= bump(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= bump(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("command pushed into a full queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= sx7_pkg::QCntW'(sx7_pkg::QDepth))
        else $error("queue count out of range");
`endif

endmodule

// ===== sv/sx7_back.sv =====
// Back end of the SysEx decoder: holds the group high bits, restores bit 7
// of data bytes and drives the output register. Depends on sx7_pkg, sx7_out_if.
module sx7_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  sx7_pkg::t_cmd  i_cmd,
    output logic           o_pop,
    sx7_out_if.source      o_out
);

    logic       r_valid;
    logic       r_kind;
    logic [7:0] r_byte;
    logic [7:0] r_high_bits;

    // A command moves on whenever the output register is free or being drained.
    assign o_pop          = !i_q_empty && (!r_valid || o_out.ready);
    assign o_out.valid    = r_valid;
    assign o_out.kind     = r_kind;
    assign o_out.out_byte = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_high_bits <= 8'd0;
        end else begin
            if (o_out.ready) begin
                r_valid <= 1'b0;
            end
            if (o_pop) begin
                unique case (i_cmd.op)
                    sx7_pkg::OP_HIGH: begin
                        r_high_bits <= i_cmd.data;
                    end
                    sx7_pkg::OP_DATA: begin
                        r_valid <= 1'b1;
                    end
                    sx7_pkg::OP_ERR: begin
                        r_valid <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.op == sx7_pkg::OP_DATA) begin
            r_kind <= sx7_pkg::KindData;
            r_byte <= {i_cmd.data[7] | r_high_bits[i_cmd.idx], i_cmd.data[6:0]};
        end else if (o_pop && i_cmd.op == sx7_pkg::OP_ERR) begin
            r_kind <= sx7_pkg::KindError;
            r_byte <= i_cmd.data;
        end
    end

`ifndef SYNTHESIS
    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !o_out.ready) |=> (r_valid && $stable(r_byte) && $stable(r_kind)))
        else $error("stalled result changed");
`endif

endmodule

// ===== sv/sysex_7bit_packet_decoder.sv =====
// Top level of the SysEx 7-bit packet decoder.
// Depends on sx7_pkg, sx7_in_if, sx7_out_if, sx7_front, sx7_fifo, sx7_back.
//
//   Channel   Direction  Payload                 Handshake
//   i_in      in         in_byte[7:0]            valid / ready
//   o_out     out        kind, out_byte[7:0]     valid / ready
//   cfg       in         i_cfg_wr_data[7:0]      i_cfg_wr_en
//
// One item is taken per cycle while the command queue has room. An item that gives
// a result is queued when it is taken and then moves into the output register,
// from which the sink takes it; the register holds the result while the sink stalls.
// A two-entry command queue separates the front end from the output stage,
// so input stalls only once the queue is full behind a stalled output.
// Synchronous active-low reset returns to hunting for a start byte and loads
// the identifier register with 0x12; no clearing pass is needed.
module sysex_7bit_packet_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sx7_in_if.sink     i_in,
    sx7_out_if.source  o_out,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data
);

    logic          push, pop, q_full, q_empty;
    sx7_pkg::t_cmd push_cmd, head_cmd;

    sx7_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (i_in),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    sx7_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_cmd   (head_cmd)
    );

    sx7_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_cmd     (head_cmd),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

// ===== tb/sv/sysex_7bit_packet_decoder_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for sysex_7bit_packet_decoder: a clocked driver and monitor
// around the block, with a decoder model that predicts every data byte and id error.
// Depends on sx7_pkg, sx7_in_if, sx7_out_if and the block itself.
module sysex_7bit_packet_decoder_tb;

    typedef enum logic [3:0] {
        FR_HUNT = 4'b0001,
        FR_ID   = 4'b0010,
        FR_HIGH = 4'b0100,
        FR_DATA = 4'b1000
    } t_frame_phase;

    typedef struct packed {
        logic       kind;
        logic [7:0] out_byte;
    } t_decoded;

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [7:0] cfg_wr_data;

    sx7_in_if  in_ch ();
    sx7_out_if out_ch ();

    sysex_7bit_packet_decoder DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in          (in_ch),
        .o_out         (out_ch),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    // Decoder model state.
    t_frame_phase frame_phase;
    logic [7:0]   id_model;
    logic [7:0]   hi_bits;
    logic [2:0]   grp_idx;

    logic [7:0] pending_bytes[$];
    t_decoded   decoded_q[$];

    bit in_taken;
    bit out_taken;
    int src_idle_max;
    int snk_idle_max;
    int src_wait;
    int snk_wait;
    int hold_requests;
    int holds_served;
    int hold_left;
    int mismatches;

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        #5ms;
        $display("FAIL sysex_7bit_packet_decoder");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // Returns 1 when the byte produces a result, with the predicted fields.
    function automatic bit decode_byte(input logic [7:0] b, output logic kind,
                                       output logic [7:0] val);
        kind = sx7_pkg::KindData;
        val  = b;
        if (frame_phase != FR_HUNT && b == sx7_pkg::EndByte) begin
            frame_phase = FR_HUNT;
            grp_idx     = 3'd0;
            return 1'b0;
        end
        case (frame_phase)
            FR_HUNT: begin
                if (b == sx7_pkg::StartByte) frame_phase = FR_ID;
                return 1'b0;
            end
            FR_ID: begin
                frame_phase = FR_HIGH;
                if (b != id_model) begin
                    kind = sx7_pkg::KindError;
                    return 1'b1;
                end
                return 1'b0;
            end
            FR_HIGH: begin
                hi_bits     = b;
                grp_idx     = 3'd0;
                frame_phase = FR_DATA;
                return 1'b0;
            end
            default: begin
                val = b | {hi_bits[grp_idx], 7'b0};
                if (grp_idx == sx7_pkg::LastIdx) begin
                    grp_idx     = 3'd0;
                    frame_phase = FR_HIGH;
                end else begin
                    grp_idx = grp_idx + 3'd1;
                end
                return 1'b1;
            end
        endcase
    endfunction

    always @(posedge clk) begin : monitor
        logic       got_kind;
        logic [7:0] got_byte;
        t_decoded   want;
        in_taken  = 1'b0;
        out_taken = 1'b0;
        if (!rst_n) begin
            frame_phase = FR_HUNT;
            id_model    = sx7_pkg::IdReset;
            hi_bits     = 8'h00;
            grp_idx     = 3'd0;
        end else begin
            if (cfg_wr_en) id_model = cfg_wr_data;
            // Check before predicting so a new item can never satisfy its own result.
            if (out_ch.valid && out_ch.ready) begin
                out_taken = 1'b1;
                if (decoded_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result kind %0d byte %02h",
                                              out_ch.kind, out_ch.out_byte));
                end else begin
                    want = decoded_q.pop_front();
                    if (out_ch.kind !== want.kind) begin
                        report_mismatch($sformatf("kind %0d, expected %0d",
                                                  out_ch.kind, want.kind));
                    end
                    if (out_ch.out_byte !== want.out_byte) begin
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  out_ch.out_byte, want.out_byte));
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                in_taken = 1'b1;
                if (decode_byte(in_ch.in_byte, got_kind, got_byte)) begin
                    decoded_q.push_back('{kind: got_kind, out_byte: got_byte});
                end
            end
        end
    end

    always @(negedge clk) begin : feeder
        logic       nxt_valid;
        logic [7:0] nxt_byte;
        nxt_valid = in_ch.valid;
        nxt_byte  = in_ch.in_byte;
        if (!rst_n) begin
            nxt_valid = 1'b0;
        end else if (!in_ch.valid || in_taken) begin
            nxt_valid = 1'b0;
            if (src_wait > 0) begin
                src_wait--;
            end else if (pending_bytes.size() > 0) begin
                nxt_byte  = pending_bytes.pop_front();
                nxt_valid = 1'b1;
                src_wait  = $urandom_range(0, src_idle_max);
            end
        end
        in_ch.valid   <= nxt_valid;
        in_ch.in_byte <= nxt_byte;
    end

    always @(negedge clk) begin : drain
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (hold_requests > holds_served) begin
                holds_served++;
                hold_left = 300;
            end
            if (out_taken) snk_wait = $urandom_range(0, snk_idle_max);
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (snk_wait > 0) begin
                snk_wait--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    function automatic logic [7:0] any_but_end();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == sx7_pkg::EndByte);
        return b;
    endfunction

    task automatic push_byte(input logic [7:0] b, inout int count);
        pending_bytes.push_back(b);
        count++;
    endtask

    // One packet with random content; now and then the id is wrong, the
    // packet is cut short, or a stray end byte lands in the data.
    task automatic queue_packet(input logic [7:0] id, inout int count);
        int         n_groups;
        int         n_data;
        logic [7:0] b;
        push_byte(sx7_pkg::StartByte, count);
        case ($urandom_range(0, 9))
            0: push_byte(8'($urandom_range(0, 255)), count);
            1: begin
                push_byte(sx7_pkg::EndByte, count);
                return;
            end
            default: push_byte(id, count);
        endcase
        n_groups = $urandom_range(0, 3);
        for (int g = 0; g < n_groups; g++) begin
            push_byte(any_but_end(), count);
            n_data = (g < n_groups - 1) ? 7 : $urandom_range(0, 7);
            for (int d = 0; d < n_data; d++) begin
                b = ($urandom_range(0, 39) == 0) ? 8'($urandom_range(0, 255))
                                                 : any_but_end();
                push_byte(b, count);
            end
        end
        if ($urandom_range(0, 9) != 0) push_byte(sx7_pkg::EndByte, count);
        // Noise between packets is ignored while hunting.
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                do b = 8'($urandom_range(0, 255)); while (b == sx7_pkg::StartByte);
                pending_bytes.push_back(b);
            end
        end
    endtask

    task automatic wait_idle();
        while (pending_bytes.size() > 0 || in_ch.valid || decoded_q.size() > 0) begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_id(input logic [7:0] value);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin : stimulus
        logic [7:0] id_values[6];
        int         count;
        in_ch.valid    = 1'b0;
        in_ch.in_byte  = 8'h00;
        out_ch.ready   = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = 8'h00;
        rst_n          = 1'b0;
        src_idle_max   = 3;
        snk_idle_max   = 3;
        src_wait       = 0;
        snk_wait       = 0;
        hold_requests  = 0;
        holds_served   = 0;
        hold_left      = 0;
        mismatches     = 0;
        count          = 0;
        id_values      = '{8'h00, 8'hFF, sx7_pkg::StartByte, sx7_pkg::EndByte,
                           8'h7F, 8'h00};
        id_values[5]   = 8'($urandom_range(0, 255));

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part with the reset identifier.
        pending_bytes = '{8'h00, sx7_pkg::EndByte,
                          sx7_pkg::StartByte, sx7_pkg::IdReset, 8'hFF,
                          8'h00, 8'h7F, 8'h80, 8'hFF, sx7_pkg::StartByte,
                          8'h01, 8'h02,
                          8'h00, 8'h55, sx7_pkg::EndByte,
                          sx7_pkg::StartByte, sx7_pkg::EndByte,
                          sx7_pkg::StartByte, 8'h34, sx7_pkg::EndByte};
        wait_idle();

        for (int p = 0; p < 6; p++) begin
            write_id(id_values[p]);
            case (p)
                0: begin src_idle_max = 7; snk_idle_max = 7; end
                1, 2: begin src_idle_max = 0; snk_idle_max = 0; end
                3: begin src_idle_max = 7; snk_idle_max = 0; end
                4: begin src_idle_max = 0; snk_idle_max = 7; end
                default: begin src_idle_max = 7; snk_idle_max = 7; end
            endcase
            count = 0;
            while (count < 270) queue_packet(id_values[p], count);
            // Output held off while the sender keeps offering items at full rate.
            if (p == 2) hold_requests++;
            wait_idle();
        end

        if (decoded_q.size() > 0) begin
            report_mismatch($sformatf("%0d results never arrived", decoded_q.size()));
        end
        if (mismatches == 0) begin
            $display("PASS sysex_7bit_packet_decoder");
        end else begin
            $display("FAIL sysex_7bit_packet_decoder");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/sx7_pkg.sv
sv/sx7_in_if.sv
sv/sx7_out_if.sv
sv/sx7_front.sv
sv/sx7_fifo.sv
sv/sx7_back.sv
sv/sysex_7bit_packet_decoder.sv
tb/sv/sysex_7bit_packet_decoder_tb.sv
